// ===== rtl/tit_pkg.sv =====
// Shared types, codes and constants for the triple interval timer.
package tit_pkg;

   localparam int TIMER_COUNT = 3;
   localparam int COUNT_W     = 16;
   localparam int TICKS_W     = 17;

   localparam logic [TICKS_W-1:0] FULL_PERIOD = 17'h10000;

   // Highest valid register index (timer 3 high byte)
   localparam logic [2:0] REG_LAST = 3'd5;

   localparam logic [7:0] IRQ_BITS [TIMER_COUNT] = '{8'h08, 8'h10, 8'h40};

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Start value of 0 stands for a full 65536-tick period
   function automatic logic [TICKS_W-1:0] period_of(input logic [COUNT_W-1:0] v);
      logic [TICKS_W-1:0] p;
      if (v == '0) begin
         p = FULL_PERIOD;
      end else begin
         p = {1'b0, v};
      end
      return p;
   endfunction

endpackage

// ===== rtl/triple_interval_timer.sv =====
// Top level of the triple interval timer: three 16-bit down timers behind six byte registers.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------------
//  req_    | in  | req_tvalid / req_tready | tuser: command; tdata: reg_index, write_data
//  rsp_    | out | rsp_tvalid / rsp_tready | tdata: read_data, irq_set_bits
//
// Every transfer in yields exactly one transfer out, in order.
// Two register stages: an input register, then the timer update and result register.
// One item per cycle is sustained while rsp_tready allows, since all three counters
// are updated together in the second stage.
// A stalled result holds in the output register; the input register keeps taking
// items as long as the stage behind it can move.
// Synchronous active-high reset stops all timers and clears all timer registers.
module triple_interval_timer
   import tit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [15:0] req_tdata,   // [2:0] reg_index, [10:3] write_data, [15:11] zero

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [15:8] irq_set_bits
);

   // Input register
   logic       in_valid_ff;
   cmd_type    in_cmd_ff;
   logic [2:0] in_idx_ff;
   logic [7:0] in_data_ff;

   // Result register
   logic       out_valid_ff;
   logic [7:0] out_rd_ff;
   logic [7:0] out_irq_ff;

   // Timer state
   logic [COUNT_W-1:0] start_ff   [TIMER_COUNT];
   logic [COUNT_W-1:0] latched_ff [TIMER_COUNT];
   logic [TICKS_W-1:0] rem_ff     [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] run_ff;

   logic [COUNT_W-1:0] start_in   [TIMER_COUNT];
   logic [COUNT_W-1:0] latched_in [TIMER_COUNT];
   logic [TICKS_W-1:0] rem_in     [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] run_in;
   logic [7:0] rd_in;
   logic [7:0] irq_in;

   logic out_free;
   logic stage_move;
   logic in_take;

   // Result register can load when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign stage_move = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign in_take    = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_irq_ff, out_rd_ff};

   // Timer update for the item in the input register
   always_comb begin
      logic [COUNT_W-1:0] nv;
      for (int t = 0; t < TIMER_COUNT; t++) begin
         start_in[t]   = start_ff[t];
         latched_in[t] = latched_ff[t];
         rem_in[t]     = rem_ff[t];
      end
      run_in = run_ff;
      rd_in  = '0;
      irq_in = '0;
      nv     = '0;
      case (in_cmd_ff)
         CMD_TICK: begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
               if (run_ff[t]) begin
                  if (rem_ff[t] <= TICKS_W'(1)) begin
                     irq_in = irq_in | IRQ_BITS[t];
                     if (t == 0) begin
                        // timer 1 reloads
                        rem_in[t] = period_of(start_ff[t]);
                     end else begin
                        // timers 2 and 3 drop to free-running full period
                        start_in[t] = '0;
                        rem_in[t]   = FULL_PERIOD;
                     end
                  end else begin
                     rem_in[t] = rem_ff[t] - TICKS_W'(1);
                  end
               end
            end
         end
         CMD_WRITE: begin
            if (in_idx_ff <= REG_LAST) begin
               for (int t = 0; t < TIMER_COUNT; t++) begin
                  if (in_idx_ff[2:1] == 2'(t)) begin
                     if (!in_idx_ff[0]) begin
                        nv            = {start_ff[t][15:8], in_data_ff};
                        run_in[t]     = 1'b0;
                        start_in[t]   = nv;
                        latched_in[t] = nv;
                     end else begin
                        nv            = {in_data_ff, start_ff[t][7:0]};
                        start_in[t]   = nv;
                        latched_in[t] = nv;
                        rem_in[t]     = period_of(nv);
                        run_in[t]     = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_READ: begin
            if (in_idx_ff <= REG_LAST) begin
               for (int t = 0; t < TIMER_COUNT; t++) begin
                  if (in_idx_ff[2:1] == 2'(t)) begin
                     rd_in = in_idx_ff[0] ? latched_ff[t][15:8] : latched_ff[t][7:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_ff       <= '0;
         for (int t = 0; t < TIMER_COUNT; t++) begin
            start_ff[t]   <= '0;
            latched_ff[t] <= '0;
            rem_ff[t]     <= '0;
         end
      end else begin
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (stage_move) begin
            in_valid_ff <= 1'b0;
         end

         if (stage_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         if (stage_move) begin
            run_ff <= run_in;
            for (int t = 0; t < TIMER_COUNT; t++) begin
               start_ff[t]   <= start_in[t];
               latched_ff[t] <= latched_in[t];
               rem_ff[t]     <= rem_in[t];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_idx_ff  <= req_tdata[2:0];
         in_data_ff <= req_tdata[10:3];
      end
      if (stage_move) begin
         out_rd_ff  <= rd_in;
         out_irq_ff <= irq_in;
      end
   end

endmodule
